FILE: design/matrix_keypad_scanner_assert.svh
// assertion macros for the keypad scanner
`ifndef MATRIX_KEYPAD_SCANNER_ASSERT_SVH
`define MATRIX_KEYPAD_SCANNER_ASSERT_SVH

// same-cycle implication, checked at every clock edge out of reset
`define MKS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("keypad scanner check failed");

// next-cycle implication, checked at every clock edge out of reset
`define MKS_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("keypad scanner check failed");

`endif

FILE: design/mks_pkg.sv
// shared types, constants and keymap for the keypad scanner
`default_nettype none

package mks_pkg;

	localparam int TICK_W   = 10;
	localparam int LEVEL_W  = 4;
	localparam int ROWOUT_W = 4;
	localparam int CHAR_W   = 7;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = 4;

	localparam logic [TICK_W-1:0] SETTLE_RST   = 10'd10;
	localparam logic [TICK_W-1:0] DEBOUNCE_RST = 10'd50;
	localparam logic [TICK_W-1:0] BEEP_RST     = 10'd100;

	localparam logic [CHAR_W-1:0] KEY_NONE    = 7'h00;
	localparam logic [CHAR_W-1:0] KEY_UNKNOWN = 7'h3f;

	// scan sequencer phases
	typedef enum logic [2:0] {
		PH_SETTLE   = 3'd0,
		PH_SCAN     = 3'd1,
		PH_DEBOUNCE = 3'd2,
		PH_BEEP     = 3'd3,
		PH_HOLD     = 3'd4,
		PH_GAP      = 3'd5
	} phase_t;

	// register index, taken from paddr[3:2]
	typedef enum logic [1:0] {
		REG_SETTLE   = 2'd0,
		REG_DEBOUNCE = 2'd1,
		REG_BEEP     = 2'd2,
		REG_SPARE    = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [TICK_W-1:0] settle;
		logic [TICK_W-1:0] debounce;
		logic [TICK_W-1:0] beep;
	} cfg_t;

	typedef struct packed {
		logic                buzzer_on;
		logic [CHAR_W-1:0]   key_char;
		logic                key_valid;
		logic [ROWOUT_W-1:0] row_drive;
	} res_t;

	// fixed 4x4 keymap: 1 2 3 A / 4 5 6 B / 7 8 9 C / * 0 # D
	function automatic logic [CHAR_W-1:0] key_of(input logic [1:0] r, input logic [1:0] c);
		logic [CHAR_W-1:0] ch;
		case ({r, c})
			4'h0: ch = 7'h31;
			4'h1: ch = 7'h32;
			4'h2: ch = 7'h33;
			4'h3: ch = 7'h41;
			4'h4: ch = 7'h34;
			4'h5: ch = 7'h35;
			4'h6: ch = 7'h36;
			4'h7: ch = 7'h42;
			4'h8: ch = 7'h37;
			4'h9: ch = 7'h38;
			4'ha: ch = 7'h39;
			4'hb: ch = 7'h43;
			4'hc: ch = 7'h2a;
			4'hd: ch = 7'h30;
			4'he: ch = 7'h23;
			4'hf: ch = 7'h44;
			default: ch = KEY_UNKNOWN;
		endcase
		return ch;
	endfunction

endpackage

`default_nettype wire

FILE: design/mks_regs.sv
// configuration register file behind the apb port
`default_nettype none

module mks_regs
	import mks_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	reg_idx_t          idx;
	logic              wr_en;
	logic [TICK_W-1:0] settle_q;
	logic [TICK_W-1:0] debounce_q;
	logic [TICK_W-1:0] beep_q;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	// register writes, low ten bits kept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q   <= SETTLE_RST;
			debounce_q <= DEBOUNCE_RST;
			beep_q     <= BEEP_RST;
		end else if (wr_en) begin
			case (idx)
				REG_SETTLE:   settle_q   <= pwdata[TICK_W-1:0];
				REG_DEBOUNCE: debounce_q <= pwdata[TICK_W-1:0];
				REG_BEEP:     beep_q     <= pwdata[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (idx)
			REG_SETTLE:   prdata = {{(DATA_W-TICK_W){1'b0}}, settle_q};
			REG_DEBOUNCE: prdata = {{(DATA_W-TICK_W){1'b0}}, debounce_q};
			REG_BEEP:     prdata = {{(DATA_W-TICK_W){1'b0}}, beep_q};
			default:      prdata = '0;
		endcase
	end

	assign cfg.settle   = settle_q;
	assign cfg.debounce = debounce_q;
	assign cfg.beep     = beep_q;

endmodule

`default_nettype wire

FILE: design/mks_core.sv
// scan sequencer: phase, row, column pointer and tick timer
`default_nettype none

module mks_core
	import mks_pkg::*;
#(
	parameter int ROW_COUNT    = 4,
	parameter int COLUMN_COUNT = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire logic [LEVEL_W-1:0] levels,
	input  wire cfg_t               cfg,
	output res_t                    res
);

	localparam int ROW_W = (ROW_COUNT > 4) ? $clog2(ROW_COUNT) : 2;
	localparam int CP_W  = ($clog2(COLUMN_COUNT + 1) > 2) ? $clog2(COLUMN_COUNT + 1) : 2;

	phase_t            phase_q, phase_d;
	logic [ROW_W-1:0]  row_q, row_d;
	logic [CP_W-1:0]   cp_q, cp_d;
	logic [TICK_W-1:0] timer_q, timer_d;

	logic [7:0]        levels_ext;
	logic              row_in_map;
	logic              cp_in_map;
	logic              cp_high;
	logic              hit_found;
	logic [CP_W-1:0]   hit_col;
	logic              settle_done;
	logic              deb_done;
	logic              beep_done;
	logic              check_hold;
	logic              release_key;
	logic [ROW_W-1:0]  row_wrap;
	logic [ROWOUT_W-1:0] row_bits;

	assign levels_ext = {{(8-LEVEL_W){1'b0}}, levels};
	assign row_in_map = ((row_q >> 2) == '0);
	assign cp_in_map  = ((cp_q >> 2) == '0);
	assign cp_high    = cp_in_map & levels[cp_q[1:0]];

	assign settle_done = (timer_q >= cfg.settle);
	assign deb_done    = (timer_q >= cfg.debounce);
	assign beep_done   = (timer_q >= cfg.beep);

	assign check_hold  = ((phase_q == PH_BEEP) & beep_done) | (phase_q == PH_HOLD);
	assign release_key = check_hold & ~cp_high;

	assign row_wrap = (row_q == ROW_W'(ROW_COUNT - 1)) ? '0 : row_q + ROW_W'(1);
	assign row_bits = row_in_map ? (ROWOUT_W'(1) << row_q[1:0]) : '0;

	// lowest high column at or above the pointer
	always_comb begin
		hit_found = 1'b0;
		hit_col   = '0;
		for (int j = COLUMN_COUNT - 1; j >= 0; j--) begin
			if (levels_ext[j] && (CP_W'(j) >= cp_q)) begin
				hit_found = 1'b1;
				hit_col   = CP_W'(j);
			end
		end
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		row_d   = row_q;
		cp_d    = cp_q;
		timer_d = timer_q;
		case (phase_q)
			PH_SETTLE, PH_SCAN: begin
				if ((phase_q == PH_SETTLE) && !settle_done) begin
					timer_d = timer_q + TICK_W'(1);
				end else if (hit_found) begin
					cp_d    = hit_col;
					phase_d = PH_DEBOUNCE;
					timer_d = '0;
				end else begin
					row_d   = row_wrap;
					cp_d    = '0;
					phase_d = PH_GAP;
					timer_d = '0;
				end
			end
			PH_DEBOUNCE: begin
				if (!deb_done) begin
					timer_d = timer_q + TICK_W'(1);
				end else if (cp_high) begin
					phase_d = PH_BEEP;
					timer_d = '0;
				end else begin
					cp_d    = cp_q + CP_W'(1);
					phase_d = PH_SCAN;
					timer_d = '0;
				end
			end
			PH_BEEP: begin
				if (!beep_done) begin
					timer_d = timer_q + TICK_W'(1);
				end else begin
					phase_d = PH_HOLD;
					timer_d = '0;
				end
			end
			PH_HOLD: ;
			PH_GAP: begin
				phase_d = PH_SETTLE;
				timer_d = '0;
			end
			default: begin
				phase_d = PH_SETTLE;
				row_d   = '0;
				cp_d    = '0;
				timer_d = '0;
			end
		endcase
		// key released: report and restart at row 0
		if (release_key) begin
			phase_d = PH_SETTLE;
			row_d   = '0;
			cp_d    = '0;
			timer_d = '0;
		end
	end

	// result fields
	always_comb begin
		res.row_drive = row_bits;
		res.key_valid = 1'b0;
		res.key_char  = KEY_NONE;
		res.buzzer_on = 1'b0;
		case (phase_q)
			PH_SETTLE, PH_SCAN, PH_DEBOUNCE, PH_HOLD: ;
			PH_BEEP: res.buzzer_on = ~beep_done;
			PH_GAP:  res.row_drive = '0;
			default: res.row_drive = '0;
		endcase
		if (release_key) begin
			res.key_valid = 1'b1;
			res.key_char  = (row_in_map & cp_in_map) ? key_of(row_q[1:0], cp_q[1:0])
			                                         : KEY_UNKNOWN;
			res.row_drive = '0;
		end
	end

	// state registers, advance once per request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SETTLE;
			row_q   <= '0;
			cp_q    <= '0;
			timer_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			row_q   <= row_d;
			cp_q    <= cp_d;
			timer_q <= timer_d;
		end
	end

endmodule

`default_nettype wire

FILE: design/mks_out.sv
// result register toward the master-side stream
`default_nettype none

module mks_out
	import mks_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire res_t        in_res,
	output logic             in_ready,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata
);

	logic valid_q;
	res_t res_q;

	// free when empty or when the held result leaves this cycle
	assign in_ready = ~valid_q | m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// payload register
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			res_q <= in_res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {{(16 - $bits(res_t)){1'b0}}, res_q};

endmodule

`default_nettype wire

FILE: design/matrix_keypad_scanner.sv
// 4x4 keypad scanner: one column sample per request, one result per request
// latency: the result for a request is on m_tdata the cycle after it is taken
// throughput: one request per cycle while s_tready is high; the state and timer
// update on each taken request, and the result register frees itself while m_tready is high
// reset: arst_n clears the sequencer to settle on row 0 and empties the result
// register; settle, debounce and beep registers return to 10, 50 and 100
`default_nettype none

module matrix_keypad_scanner
	import mks_pkg::*;
#(
	parameter int ROW_COUNT    = 4,
	parameter int COLUMN_COUNT = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// apb configuration port
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	// slave side
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [7:0]        s_tdata,  // [3:0] column_levels
	// master side
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [15:0]            m_tdata   // [3:0] row_drive, [4] key_valid,
	                                         // [11:5] key_char, [12] buzzer_on
);

	`include "matrix_keypad_scanner_assert.svh"

	cfg_t cfg;
	res_t res;
	logic accept;

	assign accept = s_tvalid & s_tready;

	mks_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mks_core #(
		.ROW_COUNT    (ROW_COUNT),
		.COLUMN_COUNT (COLUMN_COUNT)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.levels (s_tdata[LEVEL_W-1:0]),
		.cfg    (cfg),
		.res    (res)
	);

	mks_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_res   (res),
		.in_ready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// a reported key never comes with a driven row or the buzzer
	`MKS_ASSERT_IMP(a_report_quiet, m_tvalid && m_tdata[4], (m_tdata[3:0] == 4'h0) && !m_tdata[12])
	// no character without a report
	`MKS_ASSERT_IMP(a_char_idle, m_tvalid && !m_tdata[4], m_tdata[11:5] == 7'h00)
	// at most one row driven
	`MKS_ASSERT_IMP(a_row_onehot, m_tvalid, $onehot0(m_tdata[3:0]))
	// every taken request leaves a result behind
	`MKS_ASSERT_NXT(a_accept_result, accept, m_tvalid)

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// self-checking testbench for the keypad scanner, stream ports plus apb setup
`default_nettype none

module tb;
	import mks_pkg::*;

	// tracks the scan sequencer and holds the results still owed by the block
	class scan_predictor;
		logic [TICK_W-1:0] settle_cfg;
		logic [TICK_W-1:0] debounce_cfg;
		logic [TICK_W-1:0] beep_cfg;
		phase_t            phase;
		logic [1:0]        row;
		logic [2:0]        col;
		logic [TICK_W-1:0] timer;
		res_t              pending_results[$];
		int                errors;
		string             keymap;

		function new();
			keymap       = "123A456B789C*0#D";
			settle_cfg   = SETTLE_RST;
			debounce_cfg = DEBOUNCE_RST;
			beep_cfg     = BEEP_RST;
			phase        = PH_SETTLE;
			row          = '0;
			col          = '0;
			timer        = '0;
			errors       = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [DATA_W-1:0] v);
			case (idx)
				REG_SETTLE: settle_cfg = v[TICK_W-1:0];
				REG_DEBOUNCE: debounce_cfg = v[TICK_W-1:0];
				REG_BEEP: beep_cfg = v[TICK_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [TICK_W-1:0] reg_value(reg_idx_t idx);
			case (idx)
				REG_SETTLE: return settle_cfg;
				REG_DEBOUNCE: return debounce_cfg;
				REG_BEEP: return beep_cfg;
				default: return '0;
			endcase
		endfunction

		function logic col_high(logic [3:0] lv);
			return (col < 3'd4) && lv[col[1:0]];
		endfunction

		// lowest high column at or above the pointer, else move to the next row
		function void scan_row(logic [3:0] lv);
			for (int j = col; j < 4; j++) begin
				if (lv[j]) begin
					col   = 3'(j);
					phase = PH_DEBOUNCE;
					timer = '0;
					return;
				end
			end
			row   = row + 2'd1;
			col   = '0;
			phase = PH_GAP;
			timer = '0;
		endfunction

		function void take_column_sample(logic [3:0] lv);
			res_t r;
			logic hold_chk;
			byte  ch;
			r             = '0;
			hold_chk      = 1'b0;
			r.row_drive   = 4'b0001 << row;
			case (phase)
				PH_SETTLE: begin
					if (timer < settle_cfg) timer = timer + 1'b1;
					else scan_row(lv);
				end
				PH_SCAN: scan_row(lv);
				PH_DEBOUNCE: begin
					if (timer < debounce_cfg) begin
						timer = timer + 1'b1;
					end else if (col_high(lv)) begin
						phase = PH_BEEP;
						timer = '0;
					end else begin
						col   = col + 3'd1;
						phase = PH_SCAN;
						timer = '0;
					end
				end
				PH_BEEP: begin
					if (timer < beep_cfg) begin
						r.buzzer_on = 1'b1;
						timer       = timer + 1'b1;
					end else begin
						phase    = PH_HOLD;
						timer    = '0;
						hold_chk = 1'b1;
					end
				end
				PH_HOLD: hold_chk = 1'b1;
				PH_GAP: begin
					r.row_drive = '0;
					phase       = PH_SETTLE;
					timer       = '0;
				end
				default: begin
					r.row_drive = '0;
					phase       = PH_SETTLE;
					row         = '0;
					col         = '0;
					timer       = '0;
				end
			endcase
			// key released: report it and restart at row 0
			if (hold_chk && !col_high(lv)) begin
				if (col < 3'd4) ch = keymap[{row, col[1:0]}];
				else ch = "?";
				r.key_valid = 1'b1;
				r.key_char  = ch[6:0];
				r.row_drive = '0;
				row         = '0;
				col         = '0;
				phase       = PH_SETTLE;
				timer       = '0;
			end
			pending_results.push_back(r);
		endfunction

		function void check_scan_result(logic [12:0] data);
			res_t got;
			res_t want;
			got = data;
			if (pending_results.size() == 0) begin
				errors++;
				$error("unexpected scan result %h", data);
				return;
			end
			want = pending_results.pop_front();
			if (got.row_drive !== want.row_drive) begin
				errors++;
				$error("row_drive expected %h actual %h", want.row_drive, got.row_drive);
			end
			if (got.key_valid !== want.key_valid) begin
				errors++;
				$error("key_valid expected %b actual %b", want.key_valid, got.key_valid);
			end
			if (got.key_char !== want.key_char) begin
				errors++;
				$error("key_char expected %h actual %h", want.key_char, got.key_char);
			end
			if (got.buzzer_on !== want.buzzer_on) begin
				errors++;
				$error("buzzer_on expected %b actual %b", want.buzzer_on, got.buzzer_on);
			end
		endfunction
	endclass

	localparam logic [3:0] DIRECTED [25] = '{
		4'hf, 4'hf, 4'hf, 4'hf, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0,
		4'h2, 4'h0, 4'h4, 4'h4, 4'h4, 4'h0, 4'h8, 4'h8, 4'h8,
		4'h8, 4'h0, 4'h1, 4'h0, 4'hf, 4'hf, 4'h0
	};

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              psel     = 1'b0;
	logic              penable  = 1'b0;
	logic              pwrite   = 1'b0;
	logic [ADDR_W-1:0] paddr    = '0;
	logic [DATA_W-1:0] pwdata   = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [7:0]        s_tdata  = '0;  // [3:0] column_levels
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [15:0]       m_tdata;        // [3:0] row_drive, [4] key_valid,
	                                   // [11:5] key_char, [12] buzzer_on

	scan_predictor sb;
	int            send_idle_pct = 30;
	int            recv_idle_pct = 87;
	int            hold_reqs     = 0;
	int            hold_done     = 0;
	int            hold_left     = 0;
	logic [15:0]   pressed       = '0;
	int            press_left    = 0;

	matrix_keypad_scanner u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// receiver: random stalls plus a single long hold-off
	always @(posedge clk) begin
		if (hold_reqs != hold_done) begin
			hold_done = hold_reqs;
			hold_left = 300;
		end
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_scan_result(m_tdata[12:0]);
	end

	task automatic send_sample(input logic [3:0] lv);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tdata  <= {4'b0000, lv};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		sb.take_column_sample(lv);
	endtask

	// apb write, then read back the stored value unless it is the spare register
	task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] v);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, v);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx != REG_SPARE) begin
			@(posedge clk);
			psel  <= 1'b1;
			paddr <= {idx, 2'b00};
			@(posedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
			if (prdata[TICK_W-1:0] !== sb.reg_value(idx)) begin
				sb.errors++;
				$error("register %0d expected %h actual %h", idx, sb.reg_value(idx),
					prdata[TICK_W-1:0]);
			end
			psel    <= 1'b0;
			penable <= 1'b0;
		end
	endtask

	// timing registers, upper bits sometimes filled with junk
	task automatic set_timing(input logic [TICK_W-1:0] st, input logic [TICK_W-1:0] db,
		input logic [TICK_W-1:0] bp);
		logic [DATA_W-1:0] junk;
		junk = ($urandom_range(2) == 0) ? $urandom : '0;
		write_reg(REG_SETTLE, {junk[DATA_W-1:TICK_W], st});
		write_reg(REG_DEBOUNCE, {junk[DATA_W-1:TICK_W], db});
		write_reg(REG_BEEP, {junk[DATA_W-1:TICK_W], bp});
		write_reg(REG_SPARE, $urandom);
	endtask

	// stop offering and wait for every owed result
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// virtual keypad: pressed keys show up on the row currently predicted
	function automatic logic [3:0] next_levels();
		logic [3:0] lv;
		int         span;
		span = int'(sb.settle_cfg) + int'(sb.debounce_cfg) + int'(sb.beep_cfg) + 40;
		if (press_left == 0) begin
			if ($urandom_range(99) < 65) begin
				pressed = 16'b1 << $urandom_range(15);
				if ($urandom_range(9) == 0) pressed |= 16'b1 << $urandom_range(15);
				press_left = $urandom_range(span, 1);
			end else begin
				pressed    = '0;
				press_left = $urandom_range(12, 1);
			end
		end else begin
			press_left--;
		end
		if ($urandom_range(99) < 10) begin
			lv = 4'($urandom_range(15));
		end else begin
			lv = pressed[{sb.row, 2'b00} +: 4];
			// contact bounce
			if ($urandom_range(99) < 4) lv[$urandom_range(3)] = ~lv[$urandom_range(3)];
		end
		return lv;
	endfunction

	// timeout
	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

	// main sequence
	initial begin
		logic [TICK_W-1:0] st, db, bp;
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: zero timings, key hits, failed rechecks, empty rows
		set_timing('0, '0, '0);
		foreach (DIRECTED[i]) send_sample(DIRECTED[i]);

		// random phases over several timing settings and idle mixes
		for (int p = 0; p < 9; p++) begin
			drain();
			case (p)
				0: begin st = '0; db = '0; bp = '0; end
				6: begin st = '1; db = '1; bp = '1; end
				7: begin st = SETTLE_RST; db = DEBOUNCE_RST; bp = BEEP_RST; end
				8: begin
					st = $urandom_range(2);
					db = $urandom_range(2);
					bp = $urandom_range(2);
				end
				default: begin
					st = $urandom_range(6);
					db = $urandom_range(6);
					bp = $urandom_range(6);
				end
			endcase
			set_timing(st, db, bp);
			if (p < 3) begin
				send_idle_pct = 30;
				recv_idle_pct = 87;
			end else if (p < 6) begin
				send_idle_pct = 87;
				recv_idle_pct = 30;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (p == 7) hold_reqs++;
			for (int i = 0; i < 150; i++) begin
				if (p == 2 && i == 75) drain();
				send_sample(next_levels());
			end
		end
		drain();

		if (sb.errors == 0 && sb.pending_results.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
